>>> hdl/bbpg_pkg.sv
// package: shared types and constants for the bevel border pixel generator
`timescale 1ns / 1ps
`default_nettype none

package bbpg_pkg;

  localparam int MaxSizeDefault = 64;

  typedef enum logic [2:0] {
    STYLE_NONE       = 3'd0,
    STYLE_FLAT       = 3'd1,
    STYLE_SINGLE     = 3'd2,
    STYLE_INSET      = 3'd3,
    STYLE_DOUBLE     = 3'd4,
    STYLE_DBL_INSET  = 3'd5
  } style_e;

  typedef enum logic [2:0] {
    PIECE_TL     = 3'd0,
    PIECE_TR     = 3'd1,
    PIECE_BL     = 3'd2,
    PIECE_BR     = 3'd3,
    PIECE_TOP    = 3'd4,
    PIECE_LEFT   = 3'd5,
    PIECE_RIGHT  = 3'd6,
    PIECE_BOTTOM = 3'd7
  } piece_e;

  typedef enum logic [1:0] {
    REG_BASE_COLOR   = 2'd0,
    REG_BORDER_SIZE  = 2'd1,
    REG_BORDER_STYLE = 2'd2,
    REG_BEVEL_WIDTH  = 2'd3
  } reg_idx_e;

endpackage

`default_nettype wire

>>> hdl/bevel_border_pixel_generator_core.sv
// top level: registered pixel generator for beveled border art
//
// usage:
//   a query beat (piece_i, column_i, row_i) is taken at a rising edge with
//   start_i high and busy_o low; busy_o stays low, so one query per clock.
//   each query passes an input register, then the pixel logic, then a
//   result register: the result shows on pixel_argb_o / outside_o with
//   valid_o high for exactly one cycle, starting at the edge after the
//   query edge. throughput is one pixel per cycle, set by the single
//   combinational stage between the two registers. the receiver cannot
//   stall; every result beat is taken when shown.
//   configuration beats come on cfg_valid_i / cfg_ready_o with cfg_index_i
//   and cfg_data_i; cfg_ready_o is always high. write only while no query
//   is in flight.
//   reset: base color 0, size 1, style flat, bevel 0, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module bevel_border_pixel_generator_core
  import bbpg_pkg::*;
#(
  parameter int MAX_SIZE = MaxSizeDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  piece_i,
  input  wire logic [5:0]  column_i,
  input  wire logic [5:0]  row_i,
  output logic             valid_o,
  output logic [31:0]      pixel_argb_o,
  output logic             outside_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] base_color_q;
  logic [6:0]  border_size_q;
  logic [2:0]  border_style_q;
  logic [6:0]  bevel_width_q;

  logic        in_valid_q;
  piece_e      piece_q;
  logic [5:0]  column_q;
  logic [5:0]  row_q;

  logic        out_valid_q;
  logic [31:0] pixel_q, pixel_d;
  logic        outside_q, outside_d;

  logic [6:0]  size_sat, size_eff, half;
  logic [2:0]  style_w;
  logic        dbl, bevelled, inset;
  logic [7:0]  a8, r8, g8, b8;
  logic [10:0] r5, g5, b5;
  logic [7:0]  r1, g1, b1;
  logic [31:0] hl_raw, ll_raw, hl, ll;
  logic [7:0]  xs, ys, sz, bv, rx, ry;
  logic        x_lo, y_lo, x_hi, y_hi, reg_a, reg_b;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_color_q   <= 32'd0;
      border_size_q  <= 7'd1;
      border_style_q <= STYLE_FLAT;
      bevel_width_q  <= 7'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BASE_COLOR:   base_color_q   <= cfg_data_i;
        REG_BORDER_SIZE:  border_size_q  <= cfg_data_i[6:0];
        REG_BORDER_STYLE: border_style_q <= cfg_data_i[2:0];
        REG_BEVEL_WIDTH:  bevel_width_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      piece_q  <= piece_e'(piece_i);
      column_q <= column_i;
      row_q    <= row_i;
    end
  end

  // effective size and style
  always_comb begin
    size_sat = ({2'b00, border_size_q} > 9'(MAX_SIZE)) ? 7'(MAX_SIZE) : border_size_q;
    half     = size_sat >> 1;
    style_w  = border_style_q;
    size_eff = size_sat;
    if (style_w == STYLE_DOUBLE && bevel_width_q > half) begin
      style_w = STYLE_SINGLE;
    end
    if (style_w == STYLE_DBL_INSET && bevel_width_q > half) begin
      style_w = STYLE_INSET;
    end
    if (size_sat == 7'd0) begin
      style_w  = STYLE_FLAT;
      size_eff = 7'd1;
    end
    if (style_w > STYLE_DBL_INSET) begin
      style_w = STYLE_FLAT;
    end
    dbl      = (style_w == STYLE_DOUBLE) || (style_w == STYLE_DBL_INSET);
    bevelled = (style_w == STYLE_SINGLE) || (style_w == STYLE_INSET);
    inset    = (style_w == STYLE_INSET) || (style_w == STYLE_DBL_INSET);
  end

  // highlight and shadow colors
  always_comb begin
    a8 = base_color_q[31:24];
    r8 = base_color_q[23:16];
    g8 = base_color_q[15:8];
    b8 = base_color_q[7:0];
    r5 = ({3'b000, r8} + {1'b0, r8, 2'b00}) >> 2;
    g5 = ({3'b000, g8} + {1'b0, g8, 2'b00}) >> 2;
    b5 = ({3'b000, b8} + {1'b0, b8, 2'b00}) >> 2;
    r1 = (r5 > {3'b000, a8}) ? a8 : r5[7:0];
    g1 = (g5 > {3'b000, a8}) ? a8 : g5[7:0];
    b1 = (b5 > {3'b000, a8}) ? a8 : b5[7:0];
    hl_raw = {a8, r1, g1, b1};
    ll_raw = {a8, 1'b0, r8[7:1], 1'b0, g8[7:1], 1'b0, b8[7:1]};
    hl = inset ? ll_raw : hl_raw;
    ll = inset ? hl_raw : ll_raw;
  end

  // pixel logic
  always_comb begin
    xs   = {2'b00, column_q};
    ys   = {2'b00, row_q};
    sz   = {1'b0, size_eff};
    bv   = {1'b0, bevel_width_q};
    rx   = sz - 8'd1 - xs;
    ry   = sz - 8'd1 - ys;
    x_lo = xs < bv;
    y_lo = ys < bv;
    x_hi = (xs + bv) >= sz;
    y_hi = (ys + bv) >= sz;
    reg_a = x_lo && y_hi;
    reg_b = x_hi && y_lo;
    pixel_d   = base_color_q;
    outside_d = 1'b0;
    if (piece_q inside {PIECE_TOP, PIECE_LEFT, PIECE_RIGHT, PIECE_BOTTOM}) begin
      outside_d = dbl ? (xs >= sz) : (column_q != 6'd0);
      if (dbl) begin
        if (x_lo) pixel_d = hl;
        else if (x_hi) pixel_d = ll;
      end else if (bevelled) begin
        pixel_d = (piece_q inside {PIECE_TOP, PIECE_LEFT}) ? hl : ll;
      end
    end else begin
      outside_d = (xs >= sz) || (ys >= sz);
      if (dbl) begin
        case (piece_q)
          PIECE_TL: begin
            if (x_hi && y_hi) pixel_d = ll;
            else if (x_lo || y_lo) pixel_d = hl;
          end
          PIECE_BR: begin
            if (x_lo && y_lo) pixel_d = hl;
            else if (x_hi || y_hi) pixel_d = ll;
          end
          PIECE_BL: begin
            if (reg_a) pixel_d = (ry >= xs) ? hl : ll;
            else if (reg_b) pixel_d = (rx > ys) ? ll : hl;
            else if (y_hi) pixel_d = ll;
            else if (x_lo) pixel_d = hl;
          end
          default: begin
            if (reg_b) pixel_d = (ys > rx) ? ll : hl;
            else if (reg_a) pixel_d = (xs > ry) ? hl : ll;
            else if (y_lo) pixel_d = hl;
            else if (x_hi) pixel_d = ll;
          end
        endcase
      end else if (bevelled) begin
        case (piece_q)
          PIECE_TL: pixel_d = hl;
          PIECE_BR: pixel_d = ll;
          default:  pixel_d = (rx > ys) ? hl : ll;
        endcase
      end
    end
    if (outside_d) begin
      pixel_d = 32'd0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      pixel_q   <= pixel_d;
      outside_q <= outside_d;
    end
  end

  assign valid_o      = out_valid_q;
  assign pixel_argb_o = pixel_q;
  assign outside_o    = outside_q;

  // checks
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 valid_o)
    else $error("result beat missing two cycles after query");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o |-> $past(in_valid_q)))
    else $error("result beat without a query in flight");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && outside_o) |-> (pixel_argb_o == 32'd0))
    else $error("pixel not zero outside the piece");

endmodule

`default_nettype wire
